@@ rtl/slps_pkg.sv @@
// Shared types, pattern codes and timing constants for the status LED pattern sequencer.
package slps_pkg;

  localparam int unsigned PatW   = 4;
  localparam int unsigned TimerW = 11;
  localparam int unsigned FlashW = 3;

  localparam logic [PatW-1:0] PAT_OFF          = 4'd0;
  localparam logic [PatW-1:0] PAT_READY        = 4'd1;
  localparam logic [PatW-1:0] PAT_DETECTING    = 4'd2;
  localparam logic [PatW-1:0] PAT_CAPTURING    = 4'd3;
  localparam logic [PatW-1:0] PAT_SAVING       = 4'd4;
  localparam logic [PatW-1:0] PAT_TRANSFERRING = 4'd5;
  localparam logic [PatW-1:0] PAT_BLE          = 4'd6;
  localparam logic [PatW-1:0] PAT_SD_ERROR     = 4'd7;
  localparam logic [PatW-1:0] PAT_CAM_ERROR    = 4'd8;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  // Timer reloads in milliseconds.
  localparam logic [TimerW-1:0] MS_FIRST      = 11'd10;
  localparam logic [TimerW-1:0] MS_CAPTURE    = 11'd60;
  localparam logic [TimerW-1:0] MS_SAVE       = 11'd100;
  localparam logic [TimerW-1:0] MS_XFER       = 11'd150;
  localparam logic [TimerW-1:0] MS_XFER_PAUSE = 11'd1700;
  localparam logic [TimerW-1:0] MS_SD         = 11'd120;
  localparam logic [TimerW-1:0] MS_SD_PAUSE   = 11'd2000;
  localparam logic [TimerW-1:0] MS_CAM        = 11'd300;

  localparam logic [FlashW-1:0] CAPTURE_FLASHES = 3'd4;
  localparam logic [FlashW-1:0] XFER_FLASHES    = 3'd4;
  localparam logic [FlashW-1:0] SD_FLASHES      = 3'd6;

  typedef struct packed {
    logic [PatW-1:0]   current_pattern;
    logic [FlashW-1:0] flash_count;
    logic              led_lit;
    logic [TimerW-1:0] timer_remaining;
    logic              timer_running;
  } slps_state_t;

endpackage

@@ rtl/slps_if.sv @@
// Valid/ready channel interfaces for the sequencer's input and result words.
interface slps_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [slps_pkg::PatW-1:0] pattern;

  modport source (output valid, output kind, output pattern, input ready);
  modport sink   (input valid, input kind, input pattern, output ready);
endinterface

interface slps_out_if;
  logic                      valid;
  logic                      ready;
  logic                      led_level;
  logic [slps_pkg::PatW-1:0] active_pattern;

  modport source (output valid, output led_level, output active_pattern, input ready);
  modport sink   (input valid, input led_level, input active_pattern, output ready);
endinterface

@@ rtl/slps_step.sv @@
// Next-state logic for one tick or pattern-change word.
module slps_step (
  input  slps_pkg::slps_state_t             state_i,
  input  logic                              kind_i,
  input  logic [slps_pkg::PatW-1:0]         pattern_i,
  output slps_pkg::slps_state_t             state_o
);

  slps_pkg::slps_state_t s;
  logic [slps_pkg::FlashW-1:0] limit;
  logic [slps_pkg::TimerW-1:0] period;
  logic [slps_pkg::TimerW-1:0] pause;
  logic counted;

  // Flash limit and periods for the transferring and SD error flash bursts.
  always_comb begin
    limit   = slps_pkg::XFER_FLASHES;
    period  = slps_pkg::MS_XFER;
    pause   = slps_pkg::MS_XFER_PAUSE;
    counted = 1'b0;
    if (state_i.current_pattern == slps_pkg::PAT_TRANSFERRING) begin
      counted = 1'b1;
    end else if (state_i.current_pattern == slps_pkg::PAT_SD_ERROR) begin
      limit   = slps_pkg::SD_FLASHES;
      period  = slps_pkg::MS_SD;
      pause   = slps_pkg::MS_SD_PAUSE;
      counted = 1'b1;
    end
  end

  always_comb begin
    s = state_i;
    if (kind_i == slps_pkg::KIND_SELECT) begin
      if (pattern_i != state_i.current_pattern) begin
        s.timer_running   = 1'b0;
        s.timer_remaining = '0;
        s.current_pattern = pattern_i;
        s.flash_count     = '0;
        if (pattern_i == slps_pkg::PAT_READY || pattern_i == slps_pkg::PAT_DETECTING) begin
          s.led_lit = 1'b1;
        end else if (pattern_i == slps_pkg::PAT_OFF) begin
          s.led_lit = 1'b0;
        end else begin
          s.timer_remaining = slps_pkg::MS_FIRST;
          s.timer_running   = 1'b1;
        end
      end
    end else if (state_i.timer_running) begin
      if (state_i.timer_remaining <= slps_pkg::TimerW'(1)) begin
        // Expiry: the timer stops first, then the pattern may re-arm it.
        s.timer_running   = 1'b0;
        s.timer_remaining = '0;
        unique case (state_i.current_pattern)
          slps_pkg::PAT_OFF: begin
            s.led_lit = 1'b0;
          end
          slps_pkg::PAT_READY, slps_pkg::PAT_DETECTING, slps_pkg::PAT_BLE: begin
            s.led_lit = 1'b1;
          end
          slps_pkg::PAT_CAPTURING: begin
            if (state_i.flash_count < slps_pkg::CAPTURE_FLASHES) begin
              s.led_lit         = ~state_i.led_lit;
              s.flash_count     = state_i.flash_count + slps_pkg::FlashW'(1);
              s.timer_remaining = slps_pkg::MS_CAPTURE;
              s.timer_running   = 1'b1;
            end else begin
              s.led_lit         = 1'b1;
              s.flash_count     = '0;
              s.current_pattern = slps_pkg::PAT_READY;
            end
          end
          slps_pkg::PAT_SAVING: begin
            s.led_lit         = ~state_i.led_lit;
            s.timer_remaining = slps_pkg::MS_SAVE;
            s.timer_running   = 1'b1;
          end
          slps_pkg::PAT_TRANSFERRING, slps_pkg::PAT_SD_ERROR: begin
            s.timer_running = counted;
            if (state_i.flash_count < limit) begin
              s.led_lit         = ~state_i.led_lit;
              s.flash_count     = state_i.flash_count + slps_pkg::FlashW'(1);
              s.timer_remaining = period;
            end else begin
              s.led_lit         = 1'b1;
              s.flash_count     = '0;
              s.timer_remaining = pause;
            end
          end
          slps_pkg::PAT_CAM_ERROR: begin
            s.led_lit         = ~state_i.led_lit;
            s.timer_remaining = slps_pkg::MS_CAM;
            s.timer_running   = 1'b1;
          end
          default: begin
            s.led_lit = 1'b1;
          end
        endcase
      end else begin
        s.timer_remaining = state_i.timer_remaining - slps_pkg::TimerW'(1);
      end
    end
    state_o = s;
  end

endmodule

@@ rtl/status_led_pattern_sequencer_core.sv @@
// Top level of the status LED pattern sequencer: input register, state update and result register.
//
// Each input word is a one-millisecond tick or a pattern selection, and each one yields
// exactly one result word with the LED level and the pattern in force after it. The block
// takes one word per clock cycle for as long as the result side keeps up; a word is
// registered on entry, and when it leaves the input register it updates the pattern
// state and loads the result register at the same edge. The pattern state is a single
// register updated by one short block of logic per word, and the result register lets
// a new word enter while the last result still waits.
// After reset the pattern is off, the LED is on and the timer is stopped.
module status_led_pattern_sequencer_core (
  input logic        clk,
  input logic        rst_n,
  slps_in_if.sink    in_ch,
  slps_out_if.source out_ch
);

  logic                      in_vld_r;
  logic                      in_kind_r;
  logic [slps_pkg::PatW-1:0] in_pattern_r;

  logic                      out_vld_r;
  logic                      led_level_r;
  logic [slps_pkg::PatW-1:0] active_pattern_r;

  slps_pkg::slps_state_t state_r;
  slps_pkg::slps_state_t state_nxt;

  logic fire;
  logic in_rdy;

  // A registered word moves on when the result register is empty or being emptied.
  assign fire   = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_rdy = !in_vld_r || fire;

  assign in_ch.ready           = in_rdy;
  assign out_ch.valid          = out_vld_r;
  assign out_ch.led_level      = led_level_r;
  assign out_ch.active_pattern = active_pattern_r;

  slps_step u_step (
    .state_i   (state_r),
    .kind_i    (in_kind_r),
    .pattern_i (in_pattern_r),
    .state_o   (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_rdy) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      in_kind_r    <= in_ch.kind;
      in_pattern_r <= in_ch.pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.current_pattern <= slps_pkg::PAT_OFF;
      state_r.flash_count     <= '0;
      state_r.led_lit         <= 1'b1;
      state_r.timer_remaining <= '0;
      state_r.timer_running   <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      led_level_r      <= state_nxt.led_lit;
      active_pattern_r <= state_nxt.current_pattern;
    end
  end

  // A stopped timer always holds zero.
  a_timer_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.timer_running |-> state_r.timer_remaining == '0)
    else $error("timer stopped with a nonzero count");

  // The flash count never exceeds the longest flash burst.
  a_flash_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.flash_count <= slps_pkg::SD_FLASHES)
    else $error("flash count out of range");

  // Reselecting the current pattern leaves the whole state untouched.
  a_same_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_kind_r == slps_pkg::KIND_SELECT
      && in_pattern_r == state_r.current_pattern |=> $stable(state_r))
    else $error("reselecting the current pattern changed the state");

  // A result is produced for every word that leaves the input register.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r && led_level_r == state_r.led_lit
      && active_pattern_r == state_r.current_pattern)
    else $error("result register does not match the updated state");

endmodule
